// File: sv/cna_pkg.sv
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types for the complex arithmetic unit: operation codes and the
// control word that travels down the pipeline with each item.
// ----------------------------------------------------------------------------
package cna_pkg;

  // Operation codes as carried on the input channel.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_MUL    = 3'd1,
    OP_DIV    = 3'd2,
    OP_MOD_A  = 3'd3,
    OP_MOD_B  = 3'd4,
    OP_CONJ_A = 3'd5,
    OP_CONJ_B = 3'd6
  } cna_op_t;

  // Control word that follows the data through every stage.
  typedef struct packed {
    cna_op_t op;
    logic    neg_re;
    logic    neg_im;
    logic    dz;
  } cna_ctrl_t;

endpackage

// File: sv/cna_in_if.sv
// ----------------------------------------------------------------------------
// cna_in_if
// Operand channel: operation code and two complex operands.
// ----------------------------------------------------------------------------
interface cna_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic signed [W-1:0] a_real;
  logic signed [W-1:0] a_imag;
  logic signed [W-1:0] b_real;
  logic signed [W-1:0] b_imag;

  modport source (output valid, output operation, output a_real, output a_imag,
                  output b_real, output b_imag, input ready);
  modport sink   (input valid, input operation, input a_real, input a_imag,
                  input b_real, input b_imag, output ready);
endinterface

// File: sv/cna_out_if.sv
// ----------------------------------------------------------------------------
// cna_out_if
// Result channel: complex result and the two status flags.
// ----------------------------------------------------------------------------
interface cna_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_real;
  logic signed [W-1:0] result_imag;
  logic                divide_by_zero;
  logic                saturated;

  modport source (output valid, output result_real, output result_imag,
                  output divide_by_zero, output saturated, input ready);
  modport sink   (input valid, input result_real, input result_imag,
                  input divide_by_zero, input saturated, output ready);
endinterface

// File: sv/cna_iter_stage.sv
// ----------------------------------------------------------------------------
// cna_iter_stage
// One registered step of the shared digit pipeline: one restoring quotient
// bit for both divide lanes and, below bit W, a root bit for the square root.
// ----------------------------------------------------------------------------
module cna_iter_stage import cna_pkg::*; #(
  parameter int W  = 32,
  parameter int EW = 97,
  parameter int I  = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  cna_ctrl_t       ctrl_i,
  input  logic [2*W-1:0]  den_i,
  input  logic [EW-1:0]   rre_i,
  input  logic [EW-1:0]   rim_i,
  input  logic [W:0]      qre_i,
  input  logic [W:0]      qim_i,
  input  logic [2*W:0]    sd_i,
  input  logic [W-1:0]    sr_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cna_ctrl_t       ctrl_o,
  output logic [2*W-1:0]  den_o,
  output logic [EW-1:0]   rre_o,
  output logic [EW-1:0]   rim_o,
  output logic [W:0]      qre_o,
  output logic [W:0]      qim_o,
  output logic [2*W:0]    sd_o,
  output logic [W-1:0]    sr_o
);

  logic            valid_r;
  cna_ctrl_t       ctrl_r;
  logic [2*W-1:0]  den_r;
  logic [EW-1:0]   rre_r, rre_nxt;
  logic [EW-1:0]   rim_r, rim_nxt;
  logic [W:0]      qre_r, qre_nxt;
  logic [W:0]      qim_r, qim_nxt;
  logic [2*W:0]    sd_r, sd_nxt;
  logic [W-1:0]    sr_r, sr_nxt;
  logic [EW-1:0]   den_sh;
  logic [W:0]      qbit;

  // Divisor aligned to this quotient bit; both lanes share it.
  assign den_sh = {{(EW-2*W){1'b0}}, den_i} << I;
  assign qbit   = (W+1)'(1) << I;

  // Restoring step on the real and imaginary remainders.
  always_comb begin
    rre_nxt = rre_i;
    qre_nxt = qre_i;
    rim_nxt = rim_i;
    qim_nxt = qim_i;
    if (rre_i >= den_sh) begin
      rre_nxt = rre_i - den_sh;
      qre_nxt = qre_i | qbit;
    end
    if (rim_i >= den_sh) begin
      rim_nxt = rim_i - den_sh;
      qim_nxt = qim_i | qbit;
    end
  end

  // Square root step: try setting this root bit against the remainder.
  if (I < W) begin : g_root
    logic [2*W:0] trial;
    assign trial = ({{(W+1){1'b0}}, sr_i} << (I+1)) + ((2*W+1)'(1) << (2*I));
    always_comb begin
      sd_nxt = sd_i;
      sr_nxt = sr_i;
      if (sd_i >= trial) begin
        sd_nxt = sd_i - trial;
        sr_nxt = sr_i | (W'(1) << I);
      end
    end
  end else begin : g_noroot
    assign sd_nxt = sd_i;
    assign sr_nxt = sr_i;
  end

  assign ready_o = !valid_r || ready_i;

  // Stage register; it loads whenever it is empty or its word moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      ctrl_r <= ctrl_i;
      den_r  <= den_i;
      rre_r  <= rre_nxt;
      rim_r  <= rim_nxt;
      qre_r  <= qre_nxt;
      qim_r  <= qim_nxt;
      sd_r   <= sd_nxt;
      sr_r   <= sr_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctrl_o  = ctrl_r;
  assign den_o   = den_r;
  assign rre_o   = rre_r;
  assign rim_o   = rim_r;
  assign qre_o   = qre_r;
  assign qim_o   = qim_r;
  assign sd_o    = sd_r;
  assign sr_o    = sr_r;

endmodule

// File: sv/complex_number_alu_core.sv
// ----------------------------------------------------------------------------
// complex_number_alu_core
// Pipelined complex arithmetic unit on signed fixed-point words: add,
// multiply, divide, modulus and conjugate, with saturation and flags.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   in_if     sink       operation, a_real, a_imag, b_real, b_imag
//   out_if    source     result_real, result_imag, divide_by_zero, saturated
//
// One word is accepted per cycle while the output is not stalled. Each word
// goes through stages 1 to 3, the digit pipeline and the output stage; each
// digit stage adds one quotient bit and, but for the first, one root bit.
// Reset clears only the stage valid bits. Each stage holds its word while the
// next one is full and stalled, so bubbles close up and nothing is lost.
// ----------------------------------------------------------------------------
module complex_number_alu_core import cna_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int WORD_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  cna_in_if.sink    in_if,
  cna_out_if.source out_if
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int SW = 2*W + 2;
  localparam int EW = (SW + F > 3*W + 1) ? SW + F : 3*W + 1;

  // ---------------- stage 1: products and simple sums ----------------
  logic                  v1_r, rdy1, rdy2, rdy3;
  cna_ctrl_t             c1_r, c1_nxt;
  logic signed [2*W-1:0] prr_r, pii_r, pri_r, pir_r, sqx_r, sqy_r;
  logic signed [W:0]     sre_r, sre_nxt, sim_r, sim_nxt;
  logic signed [W-1:0]   mx, my;
  cna_op_t               op_in;

  assign op_in = cna_op_t'(in_if.operation);
  assign mx    = (op_in == OP_MOD_A) ? in_if.a_real : in_if.b_real;
  assign my    = (op_in == OP_MOD_A) ? in_if.a_imag : in_if.b_imag;

  // Add and conjugate results need no product.
  always_comb begin
    c1_nxt        = '0;
    c1_nxt.op     = op_in;
    c1_nxt.dz     = (op_in == OP_DIV) && (in_if.b_real == '0) && (in_if.b_imag == '0);
    sre_nxt       = '0;
    sim_nxt       = '0;
    case (op_in)
      OP_ADD: begin
        sre_nxt = {in_if.a_real[W-1], in_if.a_real} + {in_if.b_real[W-1], in_if.b_real};
        sim_nxt = {in_if.a_imag[W-1], in_if.a_imag} + {in_if.b_imag[W-1], in_if.b_imag};
      end
      OP_CONJ_A: begin
        sre_nxt = {in_if.a_real[W-1], in_if.a_real};
        sim_nxt = -{in_if.a_imag[W-1], in_if.a_imag};
      end
      OP_CONJ_B: begin
        sre_nxt = {in_if.b_real[W-1], in_if.b_real};
        sim_nxt = -{in_if.b_imag[W-1], in_if.b_imag};
      end
      default: begin
        sre_nxt = '0;
        sim_nxt = '0;
      end
    endcase
  end

  assign in_if.ready = rdy1;
  assign rdy1        = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_r  <= c1_nxt;
      sre_r <= sre_nxt;
      sim_r <= sim_nxt;
      prr_r <= in_if.a_real * in_if.b_real;
      pii_r <= in_if.a_imag * in_if.b_imag;
      pri_r <= in_if.a_real * in_if.b_imag;
      pir_r <= in_if.a_imag * in_if.b_real;
      sqx_r <= mx * mx;
      sqy_r <= my * my;
    end
  end

  // ---------------- stage 2: sums of products ----------------
  logic                  v2_r;
  cna_ctrl_t             c2_r;
  logic signed [SW-1:0]  re2_r, re2_nxt, im2_r, im2_nxt;
  logic [2*W-1:0]        sq2_r;
  logic signed [SW-1:0]  xrr, xii, xri, xir;

  assign xrr = {{(SW-2*W){prr_r[2*W-1]}}, prr_r};
  assign xii = {{(SW-2*W){pii_r[2*W-1]}}, pii_r};
  assign xri = {{(SW-2*W){pri_r[2*W-1]}}, pri_r};
  assign xir = {{(SW-2*W){pir_r[2*W-1]}}, pir_r};

  always_comb begin
    case (c1_r.op)
      OP_MUL: begin
        re2_nxt = xrr - xii;
        im2_nxt = xri + xir;
      end
      OP_DIV: begin
        re2_nxt = xrr + xii;
        im2_nxt = xir - xri;
      end
      OP_ADD, OP_CONJ_A, OP_CONJ_B: begin
        re2_nxt = {{(SW-W-1){sre_r[W]}}, sre_r};
        im2_nxt = {{(SW-W-1){sim_r[W]}}, sim_r};
      end
      default: begin
        re2_nxt = '0;
        im2_nxt = '0;
      end
    endcase
  end

  assign rdy2 = !v2_r || rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      c2_r  <= c1_r;
      re2_r <= re2_nxt;
      im2_r <= im2_nxt;
      sq2_r <= sqx_r + sqy_r;
    end
  end

  // ---------------- stage 3: sign, magnitude and dividend ----------------
  logic                  v3_r;
  cna_ctrl_t             c3_r, c3_nxt;
  logic [SW-1:0]         mre, mim;
  logic [EW-1:0]         nre_r, nre_nxt, nim_r, nim_nxt;
  logic [2*W-1:0]        den3_r, den3_nxt;
  logic [2*W:0]          sd3_r;
  logic                  it_rdy0;

  assign mre = re2_r[SW-1] ? SW'(-re2_r) : SW'(re2_r);
  assign mim = im2_r[SW-1] ? SW'(-im2_r) : SW'(im2_r);

  // Operations other than divide go through the divider with a divisor of
  // one, which also gives their overflow bit.
  always_comb begin
    c3_nxt        = c2_r;
    c3_nxt.neg_re = re2_r[SW-1];
    c3_nxt.neg_im = im2_r[SW-1];
    den3_nxt      = (2*W)'(1);
    case (c2_r.op)
      OP_MUL: begin
        nre_nxt = {{(EW-SW){1'b0}}, mre} >> F;
        nim_nxt = {{(EW-SW){1'b0}}, mim} >> F;
      end
      OP_DIV: begin
        nre_nxt  = {{(EW-SW){1'b0}}, mre} << F;
        nim_nxt  = {{(EW-SW){1'b0}}, mim} << F;
        den3_nxt = sq2_r;
      end
      OP_ADD, OP_CONJ_A, OP_CONJ_B: begin
        nre_nxt = {{(EW-SW){1'b0}}, mre};
        nim_nxt = {{(EW-SW){1'b0}}, mim};
      end
      default: begin
        nre_nxt = '0;
        nim_nxt = '0;
      end
    endcase
  end

  assign rdy3 = !v3_r || it_rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      c3_r   <= c3_nxt;
      nre_r  <= nre_nxt;
      nim_r  <= nim_nxt;
      den3_r <= den3_nxt;
      sd3_r  <= {1'b0, sq2_r};
    end
  end

  // ---------------- digit pipeline: quotient bits W down to 0 ----------------
  logic [W+1:0]    it_valid;
  logic [W+1:0]    it_ready;
  cna_ctrl_t       it_ctrl [0:W+1];
  logic [2*W-1:0]  it_den  [0:W+1];
  logic [EW-1:0]   it_rre  [0:W+1];
  logic [EW-1:0]   it_rim  [0:W+1];
  logic [W:0]      it_qre  [0:W+1];
  logic [W:0]      it_qim  [0:W+1];
  logic [2*W:0]    it_sd   [0:W+1];
  logic [W-1:0]    it_sr   [0:W+1];
  logic            rdy_f;

  assign it_valid[0] = v3_r;
  assign it_rdy0     = it_ready[0];
  assign it_ctrl[0]  = c3_r;
  assign it_den[0]   = den3_r;
  assign it_rre[0]   = nre_r;
  assign it_rim[0]   = nim_r;
  assign it_qre[0]   = '0;
  assign it_qim[0]   = '0;
  assign it_sd[0]    = sd3_r;
  assign it_sr[0]    = '0;
  assign it_ready[W+1] = rdy_f;

  for (genvar k = 0; k <= W; k++) begin : g_iter
    cna_iter_stage #(.W(W), .EW(EW), .I(W-k)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (it_valid[k]),
      .ready_o (it_ready[k]),
      .ctrl_i  (it_ctrl[k]),
      .den_i   (it_den[k]),
      .rre_i   (it_rre[k]),
      .rim_i   (it_rim[k]),
      .qre_i   (it_qre[k]),
      .qim_i   (it_qim[k]),
      .sd_i    (it_sd[k]),
      .sr_i    (it_sr[k]),
      .valid_o (it_valid[k+1]),
      .ready_i (it_ready[k+1]),
      .ctrl_o  (it_ctrl[k+1]),
      .den_o   (it_den[k+1]),
      .rre_o   (it_rre[k+1]),
      .rim_o   (it_rim[k+1]),
      .qre_o   (it_qre[k+1]),
      .qim_o   (it_qim[k+1]),
      .sd_o    (it_sd[k+1]),
      .sr_o    (it_sr[k+1])
    );
  end

  // ---------------- output stage: saturation and flags ----------------
  logic                out_valid_r;
  cna_ctrl_t           cf, cout_r;
  logic [W:0]          fre, fim, lim_re, lim_im;
  logic                clip_re, clip_im;
  logic [W:0]          ure, uim;
  logic [W-1:0]        ore_r, ore_nxt, oim_r, oim_nxt;
  logic                dz_r, sat_r, sat_nxt;

  assign cf = it_ctrl[W+1];

  always_comb begin
    if (cf.op == OP_MOD_A || cf.op == OP_MOD_B) begin
      fre = {1'b0, it_sr[W+1]};
      fim = '0;
    end else begin
      fre = it_qre[W+1];
      fim = it_qim[W+1];
    end
    lim_re  = cf.neg_re ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    lim_im  = cf.neg_im ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    clip_re = fre > lim_re;
    clip_im = fim > lim_im;
    ure     = clip_re ? lim_re : fre;
    uim     = clip_im ? lim_im : fim;
    ore_nxt = cf.neg_re ? W'(-ure) : W'(ure);
    oim_nxt = cf.neg_im ? W'(-uim) : W'(uim);
    sat_nxt = clip_re || clip_im;
    if (cf.dz) begin
      ore_nxt = '0;
      oim_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  assign rdy_f = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_f) begin
      out_valid_r <= it_valid[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      cout_r <= cf;
      ore_r  <= ore_nxt;
      oim_r  <= oim_nxt;
      dz_r   <= cf.dz;
      sat_r  <= sat_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.result_real    = ore_r;
  assign out_if.result_imag    = oim_r;
  assign out_if.divide_by_zero = dz_r;
  assign out_if.saturated      = sat_r;

  // ---------------- assertions ----------------
  logic pipe_full;
  assign pipe_full = v1_r && v2_r && v3_r && (&it_valid[W+1:1]) && out_valid_r;

  // A full pipeline with a stalled output must refuse new words.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_full && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while the pipeline is full and stalled");

  // A divide by zero gives a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.divide_by_zero) |->
      (out_if.result_real == '0 && out_if.result_imag == '0 && !out_if.saturated))
    else $error("divide by zero result is not zero");

  // Modulus words carry no imaginary part and never flag a divide by zero.
  a_mod_imag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (cout_r.op == OP_MOD_A || cout_r.op == OP_MOD_B)) |->
      (out_if.result_imag == '0 && !out_if.divide_by_zero))
    else $error("modulus result has an imaginary part");

endmodule
